/* rtl/hsd_pkg.sv */
// shared types and constants for the hamming single-error-correcting decoder
`timescale 1ns / 1ps

package hsd_pkg;

    // result status codes
    typedef enum logic [1:0] {
        STATUS_CLEAN         = 2'd0,
        STATUS_CORRECTED     = 2'd1,
        STATUS_UNCORRECTABLE = 2'd2
    } status_t;

    // configuration register word index
    localparam logic REG_CODE_LENGTH = 1'b0;

    // configuration field width and reset value
    localparam int unsigned CFG_LEN_W = 6;
    localparam logic [CFG_LEN_W-1:0] CODE_LENGTH_RESET = 6'd7;

endpackage

/* rtl/hamming_sec_decoder.sv */
// top level: configuration register, input register, decode and result register
`timescale 1ns / 1ps

// single-error-correcting hamming decoder
//
// code channel: codeword with code_valid / code_stall; a word is taken at a
// rising edge with code_valid high and code_stall low. bit i-1 is position i.
// result channel: data_bits, data_length, syndrome, status with
// result_valid / result_stall, same rule.
// the word is captured in an input register, decoded by xor trees and fixed
// wiring, and the result lands in an output register.
// throughput is one word per cycle; both registers move together whenever
// the result register is empty or being taken.
// when the receiver stalls, the result holds and one more word can still be
// held in the input register before code_stall rises.
// code_length is written over the apb port (byte address 0); values below 3
// decode as 3 and values above MAX_CODE_LEN as MAX_CODE_LEN.
// reset empties both registers and sets code_length to 7.

module hamming_sec_decoder #(
    parameter int unsigned MAX_CODE_LEN = 63
) (
    input  logic                                            clk,
    input  logic                                            rst_n,
    // apb configuration port
    input  logic                                            psel,
    input  logic                                            penable,
    input  logic                                            pwrite,
    input  logic [2:0]                                      paddr,
    input  logic [31:0]                                     pwdata,
    output logic [31:0]                                     prdata,
    output logic                                            pready,
    // code channel
    input  logic                                            code_valid,
    output logic                                            code_stall,
    input  logic [MAX_CODE_LEN-1:0]                         codeword,
    // result channel
    output logic                                            result_valid,
    input  logic                                            result_stall,
    output logic [MAX_CODE_LEN-$clog2(MAX_CODE_LEN+1)-1:0]  data_bits,
    output logic [$clog2(MAX_CODE_LEN+1)-1:0]               data_length,
    output logic [$clog2(MAX_CODE_LEN+1)-1:0]               syndrome,
    output hsd_pkg::status_t                                status
);

    import hsd_pkg::*;

    localparam int unsigned LEN_W  = $clog2(MAX_CODE_LEN + 1);
    localparam int unsigned DATA_W = MAX_CODE_LEN - LEN_W;

    // configuration
    logic [CFG_LEN_W-1:0]    code_length_reg;
    logic [LEN_W-1:0]        len_eff;
    logic                    cfg_write;

    // input register
    logic                    in_valid_reg;
    logic [MAX_CODE_LEN-1:0] in_word_reg;

    // decoded word
    logic [DATA_W-1:0]       dec_data;
    logic [LEN_W-1:0]        dec_length;
    logic [LEN_W-1:0]        dec_syndrome;
    status_t                 dec_status;

    // output register
    logic                    out_valid_reg;
    logic [DATA_W-1:0]       out_data_reg;
    logic [LEN_W-1:0]        out_length_reg;
    logic [LEN_W-1:0]        out_syndrome_reg;
    status_t                 out_status_reg;

    logic                    advance;

    // apb: always ready, word index is paddr[2]
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && (paddr[2] == REG_CODE_LENGTH);
    assign prdata    = (paddr[2] == REG_CODE_LENGTH) ?
                       {{(32 - CFG_LEN_W){1'b0}}, code_length_reg} : 32'd0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            code_length_reg <= CODE_LENGTH_RESET;
        end
        else if (cfg_write)
        begin
            code_length_reg <= pwdata[CFG_LEN_W-1:0];
        end
    end

    // clamp the length into the decodable range
    always_comb
    begin
        if (code_length_reg < CFG_LEN_W'(3))
        begin
            len_eff = LEN_W'(3);
        end
        else if (code_length_reg > CFG_LEN_W'(MAX_CODE_LEN))
        begin
            len_eff = LEN_W'(MAX_CODE_LEN);
        end
        else
        begin
            len_eff = LEN_W'(code_length_reg);
        end
    end

    // the output register is free when empty or being taken this cycle
    assign advance    = !out_valid_reg || !result_stall;
    assign code_stall = in_valid_reg && !advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (!code_stall)
        begin
            in_valid_reg <= code_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (code_valid && !code_stall)
        begin
            in_word_reg <= codeword;
        end
    end

    hsd_core #(
        .MAX_CODE_LEN (MAX_CODE_LEN)
    ) u_core (
        .word        (in_word_reg),
        .len         (len_eff),
        .data_bits   (dec_data),
        .data_length (dec_length),
        .syndrome    (dec_syndrome),
        .status      (dec_status)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= in_valid_reg;
        end
    end

    // payload only loads when a decoded word moves forward
    always_ff @(posedge clk)
    begin
        if (advance && in_valid_reg)
        begin
            out_data_reg     <= dec_data;
            out_length_reg   <= dec_length;
            out_syndrome_reg <= dec_syndrome;
            out_status_reg   <= dec_status;
        end
    end

    assign result_valid = out_valid_reg;
    assign data_bits    = out_data_reg;
    assign data_length  = out_length_reg;
    assign syndrome     = out_syndrome_reg;
    assign status       = out_status_reg;

endmodule

/* rtl/hsd_core.sv */
// combinational decode: syndrome, single-bit correction and data compaction
`timescale 1ns / 1ps

module hsd_core #(
    parameter int unsigned MAX_CODE_LEN = 63
) (
    input  logic [MAX_CODE_LEN-1:0]                                     word,
    input  logic [$clog2(MAX_CODE_LEN+1)-1:0]                           len,
    output logic [MAX_CODE_LEN-$clog2(MAX_CODE_LEN+1)-1:0]              data_bits,
    output logic [$clog2(MAX_CODE_LEN+1)-1:0]                           data_length,
    output logic [$clog2(MAX_CODE_LEN+1)-1:0]                           syndrome,
    output hsd_pkg::status_t                                            status
);

    import hsd_pkg::*;

    localparam int unsigned LEN_W  = $clog2(MAX_CODE_LEN + 1);

    logic [MAX_CODE_LEN-1:0] masked;
    logic [MAX_CODE_LEN-1:0] fixed;
    logic [LEN_W-1:0]        syn;
    logic [LEN_W-1:0]        parity_count;
    logic                    fix_en;

    // drop bits beyond the code length, then xor positions of set bits
    always_comb
    begin
        syn = '0;
        for (int unsigned pos = 1; pos <= MAX_CODE_LEN; pos++)
        begin
            masked[pos-1] = word[pos-1] && (LEN_W'(pos) <= len);
            if (masked[pos-1])
            begin
                syn = syn ^ LEN_W'(pos);
            end
        end
    end

    // parity bits in use = bit length of len
    always_comb
    begin
        parity_count = '0;
        for (int unsigned i = 0; i < LEN_W; i++)
        begin
            if (len[i])
            begin
                parity_count = LEN_W'(i + 1);
            end
        end
    end

    assign fix_en = (syn != '0) && (syn <= len);

    always_comb
    begin
        for (int unsigned pos = 1; pos <= MAX_CODE_LEN; pos++)
        begin
            fixed[pos-1] = masked[pos-1] ^ (fix_en && (syn == LEN_W'(pos)));
        end
    end

    always_comb
    begin
        if (syn == '0)
        begin
            status = STATUS_CLEAN;
        end
        else if (fix_en)
        begin
            status = STATUS_CORRECTED;
        end
        else
        begin
            status = STATUS_UNCORRECTABLE;
        end
    end

    // data positions map to fixed output bits: index = pos - 1 - bitlen(pos)
    for (genvar pos = 3; pos <= MAX_CODE_LEN; pos++)
    begin : g_compact
        if ((pos & (pos - 1)) != 0)
        begin : g_data
            assign data_bits[pos - 1 - $clog2(pos + 1)] = fixed[pos-1];
        end
    end

    assign data_length = len - parity_count;
    assign syndrome    = syn;

endmodule

/* tb/tb_hamming_sec_decoder.sv */
// self-checking testbench for the hamming single-error-correcting decoder
`timescale 1ns / 1ps

module tb_hamming_sec_decoder;

    import hsd_pkg::*;

    localparam int unsigned CODE_W  = 63;
    localparam int unsigned DATA_W  = 57;
    localparam int unsigned FIELD_W = 6;
    localparam int unsigned CYCLE_LIMIT = 300000;

    // apb byte addresses: register 0 is code_length, index 1 is unmapped
    localparam logic [2:0] ADDR_CODE_LENGTH = {REG_CODE_LENGTH, 2'b00};
    localparam logic [2:0] ADDR_UNMAPPED    = 3'd4;

    // kinds of random codeword
    typedef enum int unsigned {
        WORD_CLEAN,
        WORD_ONE_ERROR,
        WORD_TWO_ERRORS,
        WORD_NOISE
    } word_kind_t;

    typedef struct packed {
        logic [DATA_W-1:0]  data_bits;
        logic [FIELD_W-1:0] data_length;
        logic [FIELD_W-1:0] syndrome;
        status_t            status;
    } decode_t;

    logic                clk;
    logic                rst_n;
    logic                psel;
    logic                penable;
    logic                pwrite;
    logic [2:0]          paddr;
    logic [31:0]         pwdata;
    logic [31:0]         prdata;
    logic                pready;
    logic                code_valid;
    logic                code_stall;
    logic [CODE_W-1:0]   codeword;
    logic                result_valid;
    logic                result_stall = 1'b0;
    logic [DATA_W-1:0]   data_bits;
    logic [FIELD_W-1:0]  data_length;
    logic [FIELD_W-1:0]  syndrome;
    status_t             status;

    // testbench copy of the code_length register
    logic [FIELD_W-1:0]  code_length_cfg;

    // decodes expected on the result channel, oldest first
    decode_t             pending_decodes[$];

    int unsigned         sender_idle_pct;
    int unsigned         receiver_stall_pct;
    int unsigned         error_count;
    int unsigned         words_sent;
    int unsigned         words_checked;
    int unsigned         length_settings;
    int unsigned         status_seen[3];
    int unsigned         cycle_count = 0;

    hamming_sec_decoder #(
        .MAX_CODE_LEN (CODE_W)
    ) uut (
        .clk          (clk),
        .rst_n        (rst_n),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready),
        .code_valid   (code_valid),
        .code_stall   (code_stall),
        .codeword     (codeword),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .data_bits    (data_bits),
        .data_length  (data_length),
        .syndrome     (syndrome),
        .status       (status)
    );

    // 12 ns clock
    initial
    begin
        clk = 1'b0;
    end

    always #6 clk = ~clk;

    // global watchdog: a hung handshake ends the run here
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d words still expected",
                     cycle_count, pending_decodes.size());
            $display("simulation failed");
            $finish;
        end
    end

    // code_length as the decoder sees it: clamped to 3 .. MAX_CODE_LEN
    function automatic int unsigned effective_len(input logic [FIELD_W-1:0] len_reg);
        int unsigned n;
        n = len_reg;
        if (n < 3)
            n = 3;
        if (n > CODE_W)
            n = CODE_W;
        return n;
    endfunction

    // expected decode of one codeword under a given code_length setting
    function automatic decode_t predict_decode(input logic [CODE_W-1:0] word,
                                               input logic [FIELD_W-1:0] len_reg);
        decode_t     res;
        int unsigned n;
        int unsigned r;
        int unsigned syn;
        int unsigned k;
        int unsigned pos;
        int unsigned t;
        n = effective_len(len_reg);
        r = 0;
        for (t = n; t != 0; t = t >> 1)
            r++;
        // bits past the code length never take part
        syn = 0;
        for (pos = 1; pos <= n; pos++)
            if (word[pos-1])
                syn ^= pos;
        syn &= (1 << r) - 1;
        res.status = STATUS_CLEAN;
        if (syn != 0)
        begin
            if (syn <= n)
            begin
                word[syn-1] = ~word[syn-1];
                res.status  = STATUS_CORRECTED;
            end
            else
            begin
                res.status = STATUS_UNCORRECTABLE;
            end
        end
        // keep only positions that are not powers of two, in order
        res.data_bits = '0;
        k = 0;
        for (pos = 1; pos <= n; pos++)
            if ((pos & (pos - 1)) != 0)
            begin
                res.data_bits[k] = word[pos-1];
                k++;
            end
        res.data_length = FIELD_W'(n - r);
        res.syndrome    = FIELD_W'(syn);
        return res;
    endfunction

    // builds a clean codeword of effective length n around the given data
    function automatic logic [CODE_W-1:0] encode_data(input logic [DATA_W-1:0] data,
                                                      input int unsigned n);
        logic [CODE_W-1:0] w;
        int unsigned       syn;
        int unsigned       k;
        int unsigned       pos;
        w   = '0;
        syn = 0;
        k   = 0;
        for (pos = 1; pos <= n; pos++)
            if ((pos & (pos - 1)) != 0)
            begin
                w[pos-1] = data[k];
                if (data[k])
                    syn ^= pos;
                k++;
            end
        // parity bits cancel the syndrome of the data bits
        for (pos = 1; pos <= n; pos = pos << 1)
            if ((syn & pos) != 0)
                w[pos-1] = 1'b1;
        return w;
    endfunction

    function automatic logic [CODE_W-1:0] random_bits();
        logic [63:0] raw;
        raw = {$urandom, $urandom};
        return raw[CODE_W-1:0];
    endfunction

    // mostly well-formed codewords with zero, one or two flipped bits
    function automatic logic [CODE_W-1:0] random_codeword(input logic [FIELD_W-1:0] len_reg);
        logic [CODE_W-1:0] w;
        logic [CODE_W-1:0] junk;
        int unsigned       n;
        int unsigned       roll;
        word_kind_t        kind;
        n    = effective_len(len_reg);
        roll = $urandom_range(99);
        if (roll < 25)
            kind = WORD_CLEAN;
        else if (roll < 65)
            kind = WORD_ONE_ERROR;
        else if (roll < 82)
            kind = WORD_TWO_ERRORS;
        else
            kind = WORD_NOISE;
        w = encode_data(DATA_W'(random_bits()), n);
        case (kind)
            WORD_ONE_ERROR:
                w[$urandom_range(n - 1)] ^= 1'b1;
            WORD_TWO_ERRORS:
            begin
                w[$urandom_range(n - 1)] ^= 1'b1;
                w[$urandom_range(n - 1)] ^= 1'b1;
            end
            WORD_NOISE:
                w = random_bits();
            default:
                ;
        endcase
        // half the time put junk above the code length, it must be ignored
        if (kind != WORD_NOISE && $urandom_range(1) == 1)
        begin
            junk = random_bits();
            w    = w | (junk & ~((CODE_W'(1) << n) - 1));
        end
        return w;
    endfunction

    // result channel: check each accepted word, stall at random
    always @(posedge clk)
    begin
        decode_t want;
        if (rst_n && result_valid && !result_stall)
        begin
            if (pending_decodes.size() == 0)
            begin
                $error("result word with nothing expected: data_bits %0h syndrome %0d",
                       data_bits, syndrome);
                error_count++;
            end
            else
            begin
                want = pending_decodes.pop_front();
                words_checked++;
                status_seen[want.status]++;
                if (data_bits !== want.data_bits)
                begin
                    $error("data_bits: expected %0h, got %0h", want.data_bits, data_bits);
                    error_count++;
                end
                if (data_length !== want.data_length)
                begin
                    $error("data_length: expected %0d, got %0d",
                           want.data_length, data_length);
                    error_count++;
                end
                if (syndrome !== want.syndrome)
                begin
                    $error("syndrome: expected %0d, got %0d", want.syndrome, syndrome);
                    error_count++;
                end
                if (status !== want.status)
                begin
                    $error("status: expected %0d, got %0d", want.status, status);
                    error_count++;
                end
            end
        end
        result_stall <= ($urandom_range(99) < receiver_stall_pct);
    end

    // offers one word, possibly after random idle cycles, and waits until taken
    task automatic send_word(input logic [CODE_W-1:0] word);
        while ($urandom_range(99) < sender_idle_pct)
        begin
            code_valid <= 1'b0;
            @(posedge clk);
        end
        code_valid <= 1'b1;
        codeword   <= word;
        do
            @(posedge clk);
        while (code_stall);
        pending_decodes.push_back(predict_decode(word, code_length_cfg));
        words_sent++;
    endtask

    // stops sending until every expected word has come back
    task automatic pause_until_drained();
        code_valid <= 1'b0;
        while (pending_decodes.size() != 0)
            @(posedge clk);
        // input and output registers: give them more edges to be sure both are empty
        repeat (4) @(posedge clk);
    endtask

    // apb write followed by a back-to-back read of the same address
    task automatic write_config(input logic [2:0] addr, input logic [31:0] value);
        pause_until_drained();
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        if (addr == ADDR_CODE_LENGTH)
        begin
            code_length_cfg = value[FIELD_W-1:0];
            length_settings++;
        end
        // read setup straight after the write access
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        if (addr == ADDR_CODE_LENGTH && prdata[FIELD_W-1:0] !== code_length_cfg)
        begin
            $error("code_length readback: expected %0d, got %0d",
                   code_length_cfg, prdata[FIELD_W-1:0]);
            error_count++;
        end
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    // reset value 7: clean word, every single-bit error, junk above the code
    task automatic test_reset_length();
        logic [CODE_W-1:0] clean;
        int unsigned       pos;
        clean = encode_data(DATA_W'(4'b1011), 7);
        send_word('0);
        send_word('1);
        send_word(clean);
        for (pos = 0; pos < 7; pos++)
            send_word(clean ^ (CODE_W'(1) << pos));
    endtask

    // longest code: all zeros, all ones, errors on the last and a parity bit
    task automatic test_longest_code();
        logic [CODE_W-1:0] clean;
        write_config(ADDR_CODE_LENGTH, 32'd63);
        clean = encode_data('1, CODE_W);
        send_word('0);
        send_word('1);
        send_word(clean ^ (CODE_W'(1) << 62));
        send_word(clean ^ (CODE_W'(1) << 31));
    endtask

    // syndrome pointing past the code length
    task automatic test_uncorrectable();
        write_config(ADDR_CODE_LENGTH, 32'd5);
        send_word(CODE_W'(5'b01100));
        write_config(ADDR_CODE_LENGTH, 32'd12);
        send_word((CODE_W'(1) << 11) | CODE_W'(1) | (CODE_W'(1) << 40));
    endtask

    // lengths below 3 decode as 3, writes to an unmapped address do nothing
    task automatic test_length_clamp();
        write_config(ADDR_CODE_LENGTH, 32'd0);
        send_word(CODE_W'(3'b111));
        send_word(CODE_W'(3'b100));
        write_config(ADDR_CODE_LENGTH, 32'd2);
        send_word(CODE_W'(3'b010));
        write_config(ADDR_UNMAPPED, 32'd20);
        send_word('1);
        write_config(ADDR_CODE_LENGTH, 32'd1);
        send_word(CODE_W'(3'b001));
    endtask

    // random codewords over a spread of lengths with one idle mix
    task automatic test_random_traffic(input int unsigned send_idle,
                                       input int unsigned recv_stall);
        int unsigned      seg;
        int unsigned      i;
        logic [FIELD_W-1:0] len_reg;
        sender_idle_pct    = send_idle;
        receiver_stall_pct = recv_stall;
        for (seg = 0; seg < 6; seg++)
        begin
            case (seg)
                0:       len_reg = 6'd63;
                1:       len_reg = 6'd3;
                2:       len_reg = FIELD_W'($urandom_range(2));
                default: len_reg = FIELD_W'($urandom_range(63));
            endcase
            write_config(ADDR_CODE_LENGTH, {26'($urandom), len_reg});
            if (seg == 3)
                write_config(ADDR_UNMAPPED, $urandom);
            for (i = 0; i < 72; i++)
            begin
                // now and then let the pipeline run completely dry
                if ($urandom_range(149) == 0)
                    pause_until_drained();
                send_word(random_codeword(code_length_cfg));
            end
        end
    endtask

    initial
    begin
        rst_n              <= 1'b0;
        psel               <= 1'b0;
        penable            <= 1'b0;
        pwrite             <= 1'b0;
        paddr              <= '0;
        pwdata             <= '0;
        code_valid         <= 1'b0;
        codeword           <= '0;
        code_length_cfg    = CODE_LENGTH_RESET;
        sender_idle_pct    = 26;
        receiver_stall_pct = 75;
        error_count        = 0;
        words_sent         = 0;
        words_checked      = 0;
        length_settings    = 1;
        status_seen        = '{0, 0, 0};
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_reset_length();
        test_longest_code();
        test_uncorrectable();
        test_length_clamp();
        test_random_traffic(26, 75);
        test_random_traffic(75, 26);
        test_random_traffic(0, 0);

        pause_until_drained();
        if (pending_decodes.size() != 0)
        begin
            $error("%0d expected words never arrived", pending_decodes.size());
            error_count++;
        end
        $display("%0d codewords sent, %0d checked, over %0d code_length settings",
                 words_sent, words_checked, length_settings);
        $display("clean %0d, corrected %0d, uncorrectable %0d; idle mixes 26/75, 75/26, 0/0",
                 status_seen[STATUS_CLEAN], status_seen[STATUS_CORRECTED],
                 status_seen[STATUS_UNCORRECTABLE]);
        if (error_count == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
